>>> hw/rtl/mfcr_pkg.sv
// Shared types and constants for the meter frame checker and reply builder.
// Holds the frame descriptor passed from front to back and the reply byte map.
// No dependencies.
package mfcr_pkg;

	localparam int COUNT_W   = 8;
	localparam int LOGIN_LEN = 22;
	localparam int DATA_LEN  = 39;
	localparam int REPLY_LEN = 18;
	localparam int IDX_W     = 5;

	localparam logic [IDX_W-1:0] REPLY_LAST_IDX = IDX_W'(REPLY_LEN - 1);

	localparam logic [7:0] CTRL_LOGIN = 8'h33;
	localparam logic [7:0] CTRL_DATA  = 8'h36;
	localparam logic [7:0] DIGIT_BIAS = 8'h33;
	localparam logic [7:0] HDR_START  = 8'h68;
	localparam logic [7:0] HDR_FILL   = 8'h88;
	localparam logic [7:0] HDR_B8     = 8'h20;
	localparam logic [7:0] HDR_B9     = 8'h06;
	localparam logic [7:0] HDR_B11    = 8'h1d;
	localparam logic [7:0] END_MARK   = 8'h16;
	localparam logic [15:0] SNOW_READING = 16'd1000;

	// mod-256 sum of the fixed reply bytes 0..9 and 11
	localparam logic [7:0] HDR_SUM = 8'((2 * 8'h68) + (6 * 8'h88) + 8'h20 + 8'h06 + 8'h1d);

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_LEN = 2'd1,
		ST_BAD_SUM = 2'd2
	} status_t;

	typedef struct packed {
		status_t            status;
		logic               kind;
		logic [3:0][7:0]    addr;
		logic [7:0]         csum;
		logic signed [15:0] reading;
		logic               is1000;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] reply_byte(input logic [IDX_W-1:0] idx, input desc_t d);
		logic [7:0] b;
		unique case (idx) inside
			5'd0, 5'd7:   b = HDR_START;
			[5'd1:5'd6]:  b = HDR_FILL;
			5'd8:         b = HDR_B8;
			5'd9:         b = HDR_B9;
			5'd10:        b = d.kind ? CTRL_DATA : CTRL_LOGIN;
			5'd11:        b = HDR_B11;
			[5'd12:5'd15]: b = d.addr[idx[1:0]];
			5'd16:        b = d.csum;
			5'd17:        b = END_MARK;
			default:      b = '0;
		endcase
		return b;
	endfunction

endpackage

>>> hw/rtl/mfcr_front.sv
// Front part: accepts frame bytes, tracks count, sum and trailing bytes,
// and on the last byte classifies the frame into one descriptor.
// Depends on mfcr_pkg.
module mfcr_front #(
	parameter int MAX_FRAME_BYTES = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  mfcr_pkg::q_stat_t   q_stat,
	output logic                push,
	output mfcr_pkg::desc_t     push_desc
);
	import mfcr_pkg::*;

	localparam logic [COUNT_W-1:0] MAX_CNT   = COUNT_W'(MAX_FRAME_BYTES);
	localparam logic [COUNT_W-1:0] LOGIN_IDX = COUNT_W'(LOGIN_LEN - 1);
	localparam logic [COUNT_W-1:0] DATA_IDX  = COUNT_W'(DATA_LEN - 1);
	localparam logic [COUNT_W-1:0] RD_LO_IDX = COUNT_W'(13);
	localparam logic [COUNT_W-1:0] RD_HI_IDX = COUNT_W'(14);

	logic [COUNT_W-1:0] count_q;
	logic [7:0]         sum_q;
	logic [4:0][7:0]    recent_q;
	logic [1:0][7:0]    rdg_q;

	logic        accept;
	logic        is_login, is_data, sum_ok;
	logic [7:0]  ck, ctrl;
	logic [15:0] rd;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && in_last;

	assign is_login = (count_q == LOGIN_IDX);
	assign is_data  = (count_q == DATA_IDX);
	assign ck       = recent_q[0];
	assign sum_ok   = (8'(sum_q - ck) == ck);
	assign ctrl     = is_data ? CTRL_DATA : CTRL_LOGIN;
	assign rd       = {8'(rdg_q[1] - DIGIT_BIAS), 8'(rdg_q[0] - DIGIT_BIAS)};

	always_comb begin
		push_desc.addr    = {recent_q[1], recent_q[2], recent_q[3], recent_q[4]};
		push_desc.csum    = 8'(HDR_SUM + ctrl + recent_q[1] + recent_q[2]
			+ recent_q[3] + recent_q[4]);
		push_desc.kind    = is_data;
		push_desc.reading = '0;
		push_desc.is1000  = 1'b0;
		if (!is_login && !is_data) begin
			push_desc.status = ST_BAD_LEN;
		end else if (!sum_ok) begin
			push_desc.status = ST_BAD_SUM;
		end else begin
			push_desc.status = ST_OK;
			if (is_data) begin
				push_desc.reading = rd;
				push_desc.is1000  = (rd == SNOW_READING);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_q    <= '0;
			recent_q <= '0;
			rdg_q    <= '0;
		end else if (accept) begin
			if (in_last) begin
				// clear for the next frame
				count_q  <= '0;
				sum_q    <= '0;
				recent_q <= '0;
				rdg_q    <= '0;
			end else begin
				if (count_q == RD_LO_IDX) rdg_q[0] <= in_byte;
				if (count_q == RD_HI_IDX) rdg_q[1] <= in_byte;
				sum_q    <= 8'(sum_q + in_byte);
				recent_q <= {recent_q[3:0], in_byte};
				if (count_q < MAX_CNT) count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/mfcr_queue.sv
// Two-entry descriptor queue between front and back.
// Depends on mfcr_pkg.
module mfcr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mfcr_pkg::desc_t   push_desc,
	input  logic              pop,
	output mfcr_pkg::desc_t   head,
	output mfcr_pkg::q_stat_t stat
);
	import mfcr_pkg::*;

	desc_t      mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> hw/rtl/mfcr_back.sv
// Back part: walks the head descriptor and emits reply bytes or one error
// result through a registered output stage. Depends on mfcr_pkg.
module mfcr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mfcr_pkg::desc_t   head,
	input  mfcr_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_last,
	output mfcr_pkg::status_t out_status,
	output logic              out_kind,
	output logic signed [15:0] out_reading,
	output logic              out_is1000
);
	import mfcr_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	logic             load, is_ok, end_item;

	assign is_ok    = (head.status == ST_OK);
	assign end_item = !is_ok || (idx_q == REPLY_LAST_IDX);
	assign load     = !q_stat.empty && (!valid_q || out_ready);
	assign pop      = load && end_item;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= end_item ? '0 : idx_q + 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// payload holds while the receiver stalls
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte    <= is_ok ? reply_byte(idx_q, head) : 8'h00;
			out_last    <= end_item;
			out_status  <= head.status;
			out_kind    <= head.kind;
			out_reading <= head.reading;
			out_is1000  <= head.is1000;
		end
	end

endmodule

>>> hw/rtl/meter_frame_check_and_reply.sv
// Meter frame checker and reply builder, top level.
// Receive side: one frame byte per word on s_axis, tlast on the final byte.
// Frames of 22 bytes (login) and 39 bytes (data) are checked against the
// mod-256 sum carried in the second-to-last byte.
// Transmit side: a valid frame yields 18 reply words on m_axis, tlast on the
// 18th; a bad length or bad checksum yields one error word with tlast set.
// Data frames also carry the decoded reading on every reply word.
// Throughput: one received byte per cycle and, while m_axis_tready is high, one result
// per cycle; the input side stalls only while the two-entry frame queue holds two frames.
// Result path: the descriptor is written into the queue as the last frame byte is taken,
// and the back end then loads each result word into its output register.
// Reset clears the frame counters, the queue and the output stage; no word
// is pending after reset. When m_axis_tready is low the output word holds,
// the back end pauses, and the front keeps taking bytes until the queue fills.
// Depends on mfcr_pkg, mfcr_front, mfcr_queue, mfcr_back.
module meter_frame_check_and_reply #(
	parameter int MAX_FRAME_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [7:0] tx_byte, [23:8] reading, [24] reading_is_1000
	output logic [7:0]  m_axis_tuser,  // [1:0] status, [2] frame_kind
	output logic        m_axis_tlast
);
	import mfcr_pkg::*;

	q_stat_t           q_stat;
	desc_t             push_desc, head;
	logic              push, pop;
	logic [7:0]        tx_byte;
	status_t           tx_status;
	logic              tx_kind, tx_is1000;
	logic signed [15:0] tx_reading;

	mfcr_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.q_stat    (q_stat),
		.push      (push),
		.push_desc (push_desc)
	);

	mfcr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	mfcr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (tx_byte),
		.out_last    (m_axis_tlast),
		.out_status  (tx_status),
		.out_kind    (tx_kind),
		.out_reading (tx_reading),
		.out_is1000  (tx_is1000)
	);

	assign m_axis_tdata = {7'b0, tx_is1000, tx_reading, tx_byte};
	assign m_axis_tuser = {5'b0, tx_kind, tx_status};

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full || pop)
		else $error("descriptor queue overflow");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty descriptor queue");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && tx_status != ST_OK) |-> m_axis_tlast && tx_byte == 8'h00)
		else $error("error result not a single final word");

	a_snow_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && tx_is1000) |->
			(tx_reading == 16'sd1000) && tx_kind && tx_status == ST_OK)
		else $error("snow flag set without a data reading of 1000");
`endif

endmodule

>>> dv/meter_frame_check_and_reply_test.sv
// Self-checking testbench for meter_frame_check_and_reply.
// Streams login, data and malformed frames, predicts every reply or error word
// in a cycle-free model of the checker; depends on mfcr_pkg and the RTL only.
`timescale 1ns / 1ps

module meter_frame_check_and_reply_test;
	import mfcr_pkg::*;

	localparam int MAX_BYTES   = 40;
	localparam int IDLE_PCT    = 34;
	localparam int HOLD_AT     = 50;    // received bytes before the long output stall
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;  // cycles with no word moving on either side
	localparam int RANDOM_BYTES = 20;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} rx_word_t;

	typedef struct {
		logic [7:0]  tx_byte;
		logic        tx_last;
		status_t     status;
		logic        frame_kind;
		logic [15:0] reading;
		logic        reading_is_1000;
	} reply_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [7:0]  m_axis_tuser;
	logic        m_axis_tlast;

	rx_word_t    frame_bytes[$];
	reply_word_t reply_words[$];
	int          total_rx = 0;
	int          rx_count = 0;
	logic        rx_taken = 1'b0;
	int          errors = 0;
	int          idle_cycles = 0;
	int          n_login = 0, n_data = 0, n_snow = 0, n_bad_len = 0, n_bad_sum = 0;

	// predictor state for the frame in progress
	int unsigned frm_len = 0;
	logic [7:0]  frm_sum = '0;
	logic [7:0]  frm_tail[6] = '{default: '0};  // entry 0 the newest byte
	logic [7:0]  frm_rd_lo = '0, frm_rd_hi = '0;

	meter_frame_check_and_reply #(.MAX_FRAME_BYTES(MAX_BYTES)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit calm();
		return rx_count >= 100 && rx_count < 150;
	endfunction

	task automatic push_reply(input logic [7:0] b, input logic last, input status_t st,
			input logic kind, input logic [15:0] rd, input logic snow);
		reply_word_t w;
		w.tx_byte = b;
		w.tx_last = last;
		w.status = st;
		w.frame_kind = kind;
		w.reading = rd;
		w.reading_is_1000 = snow;
		reply_words.push_back(w);
	endtask

	task automatic absorb_rx_byte(input logic [7:0] b, input logic last);
		int unsigned n;
		logic        kind;
		logic [7:0]  reply[REPLY_LEN];
		logic [7:0]  csum;
		logic [15:0] rd;
		logic        snow;
		if (!last) begin
			if (frm_len == 13)
				frm_rd_lo = b;
			else if (frm_len == 14)
				frm_rd_hi = b;
			frm_sum = 8'(frm_sum + b);
			for (int i = 5; i > 0; i--)
				frm_tail[i] = frm_tail[i-1];
			frm_tail[0] = b;
			if (frm_len < MAX_BYTES)
				frm_len++;
			return;
		end
		n = frm_len + 1;
		if (n > MAX_BYTES)
			n = MAX_BYTES;
		if (n != LOGIN_LEN && n != DATA_LEN) begin
			push_reply('0, 1'b1, ST_BAD_LEN, 1'b0, '0, 1'b0);
		end else begin
			kind = (n == DATA_LEN);
			if (8'(frm_sum - frm_tail[0]) != frm_tail[0]) begin
				push_reply('0, 1'b1, ST_BAD_SUM, kind, '0, 1'b0);
			end else begin
				reply = '{HDR_START, HDR_FILL, HDR_FILL, HDR_FILL, HDR_FILL, HDR_FILL,
					HDR_FILL, HDR_START, HDR_B8, HDR_B9, kind ? CTRL_DATA : CTRL_LOGIN,
					HDR_B11, frm_tail[4], frm_tail[3], frm_tail[2], frm_tail[1],
					8'h00, END_MARK};
				csum = '0;
				for (int i = 0; i < 16; i++)
					csum = 8'(csum + reply[i]);
				reply[16] = csum;
				rd = '0;
				if (kind)
					rd = {8'(frm_rd_hi - DIGIT_BIAS), 8'(frm_rd_lo - DIGIT_BIAS)};
				snow = kind && (rd == SNOW_READING);
				for (int i = 0; i < REPLY_LEN; i++)
					push_reply(reply[i], i == REPLY_LEN - 1, ST_OK, kind, rd, snow);
			end
		end
		frm_len = 0;
		frm_sum = '0;
		frm_tail = '{default: '0};
		frm_rd_lo = '0;
		frm_rd_hi = '0;
	endtask

	// fill < 0 gives random bytes, otherwise every byte is fill, before the reading and checksum bytes are set
	task automatic queue_meter_frame(input int len, input int fill, input bit good_sum,
			input bit set_rd, input logic [15:0] rd);
		logic [7:0] b[];
		logic [7:0] s;
		rx_word_t   w;
		b = new[len];
		for (int i = 0; i < len; i++)
			b[i] = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
		if (set_rd && len > 14) begin
			b[13] = 8'(rd[7:0] + DIGIT_BIAS);
			b[14] = 8'(rd[15:8] + DIGIT_BIAS);
		end
		if (len >= 2) begin
			s = '0;
			for (int i = 0; i < len - 2; i++)
				s = 8'(s + b[i]);
			b[len-2] = good_sum ? s : 8'(s + $urandom_range(1, 255));
		end
		for (int i = 0; i < len; i++) begin
			w.data = b[i];
			w.last = (i == len - 1);
			frame_bytes.push_back(w);
		end
		total_rx += len;
	endtask

	function automatic void check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			errors++;
		end
	endfunction

	// drive the receive side; advance only after the current word is taken
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || rx_taken)) begin
			if (frame_bytes.size() > 0 && (calm() || $urandom_range(99) >= IDLE_PCT)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= frame_bytes[0].data;
				s_axis_tlast <= frame_bytes[0].last;
				void'(frame_bytes.pop_front());
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// drive the transmit ready, with one long hold-off while frames keep arriving
	always @(negedge clk) begin : drive_tx_ready
		static int hold_left = 0;
		static bit hold_done = 1'b0;
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && rx_count >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n && (calm() || $urandom_range(99) >= IDLE_PCT);
		end
	end

	// sample both sides, predict on accepted bytes, compare accepted words
	always @(posedge clk) begin : watch_ports
		reply_word_t want;
		rx_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			absorb_rx_byte(s_axis_tdata, s_axis_tlast);
			rx_count++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (reply_words.size() == 0) begin
				$error("unexpected output word 0x%0h user 0x%0h", m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = reply_words.pop_front();
				check_field("tx_byte", want.tx_byte, m_axis_tdata[7:0]);
				check_field("tx_last", want.tx_last, m_axis_tlast);
				check_field("status", want.status, m_axis_tuser[1:0]);
				check_field("frame_kind", want.frame_kind, m_axis_tuser[2]);
				check_field("reading", want.reading, m_axis_tdata[23:8]);
				check_field("reading_is_1000", want.reading_is_1000, m_axis_tdata[24]);
				if (want.tx_last) begin
					case (want.status)
						ST_BAD_LEN: n_bad_len++;
						ST_BAD_SUM: n_bad_sum++;
						default: begin
							if (want.frame_kind)
								n_data++;
							else
								n_login++;
							if (want.reading_is_1000)
								n_snow++;
						end
					endcase
				end
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("traffic stopped: %0d bytes in, %0d words pending", rx_count,
				reply_words.size());
			$display("meter_frame_check_and_reply test failed");
			$finish;
		end
	end

	initial begin
		int start;
		int pick;
		// directed frames
		queue_meter_frame(1, -1, 1'b1, 1'b0, '0);              // single-byte frame
		queue_meter_frame(LOGIN_LEN, 8'h00, 1'b1, 1'b0, '0);   // login of all zeros
		queue_meter_frame(DATA_LEN, -1, 1'b1, 1'b1, 16'd1000); // snow reading
		queue_meter_frame(DATA_LEN, -1, 1'b0, 1'b1, 16'd1000); // bad checksum, data
		queue_meter_frame(2, 8'h00, 1'b1, 1'b0, '0);
		queue_meter_frame(MAX_BYTES + 3, -1, 1'b1, 1'b0, '0);  // past the length cap

		// random frames, a mix of good and broken
		start = total_rx;
		while (total_rx - start < RANDOM_BYTES) begin
			pick = $urandom_range(99);
			if (pick < 25)
				queue_meter_frame(LOGIN_LEN, -1, 1'b1, 1'b0, '0);
			else if (pick < 45)
				queue_meter_frame(DATA_LEN, -1, 1'b1, 1'b0, '0);
			else if (pick < 60)
				queue_meter_frame(LOGIN_LEN, -1, 1'b0, 1'b0, '0);
			else if (pick < 85)
				queue_meter_frame($urandom_range(1, 8), -1, $urandom_range(1), 1'b0, '0);
			else
				queue_meter_frame($urandom_range(9, MAX_BYTES + 5), -1, 1'b1, 1'b0, '0);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (rx_count == total_rx);
		wait (reply_words.size() == 0);
		repeat (20) @(posedge clk);
		if (reply_words.size() != 0) begin
			$error("%0d reply words never arrived", reply_words.size());
			errors++;
		end
		$display("Sent %0d frame bytes; saw %0d login and %0d data replies (%0d snow),",
			total_rx, n_login, n_data, n_snow);
		$display("  %0d length errors and %0d checksum errors; %0d mismatches.",
			n_bad_len, n_bad_sum, errors);
		if (errors == 0)
			$display("meter_frame_check_and_reply test passed");
		else
			$display("meter_frame_check_and_reply test failed");
		$finish;
	end

endmodule
